// ===== rtl/flpms_pkg.sv =====
// Shared widths and command/status codes for the slot pool with mark and sweep.
`default_nettype none

package flpms_pkg;

    localparam int CMD_W  = 3;
    localparam int SLOT_W = 8;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 9;

    // Command codes; codes above CMD_SWEEP are ignored and answer done.
    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWEEP = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 9'd256;

endpackage

`default_nettype wire

// ===== rtl/flpms_if.sv =====
// Command and result channel interfaces for the slot pool.
`default_nettype none

interface flpms_cmd_if import flpms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

interface flpms_res_if import flpms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] result_slot;
    logic [STAT_W-1:0] status;

    modport source (output valid, output result_slot, output status, input ready);
    modport sink   (input valid, input result_slot, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/free_list_pool_with_mark_sweep.sv =====
// Top level: slot pool with a linked free list and mark-and-sweep reclamation.
`default_nettype none

// Slot pool allocator. Free slots are chained through a next-slot memory
// (one synchronous RAM) with the list head in a register; live marks sit
// in a second one-bit RAM. Every command returns exactly one result
// transaction (result_slot, status). Per command: free, mark and unknown
// codes finish in the accept cycle; allocate reads the head's successor
// from the next-slot RAM, then finishes; init writes one entry of each RAM
// per cycle after the accept cycle over min(POOL_SLOTS,256) entries; sweep
// walks the free list (read-then-follow on the next-slot RAM), then
// visits each slot below the pool size (read-then-update of the mark RAM).
// A finished result goes to the output register if that stage is free.
// After reset the mark RAM is cleared by a pass over min(POOL_SLOTS,256)
// entries during which no command is accepted; pool_size writes are taken
// at any time. A finished result waits in a pending register if the output
// stage is still held; the next command is accepted once the engine is idle.
// Allocating from an empty list answers status 1, freeing or marking a slot
// at or above the pool size answers status 2 and changes nothing. Double
// frees are not caught; the sweep walk of the free list stops after
// POOL_SLOTS steps so a looped list cannot hang it.

module free_list_pool_with_mark_sweep
    import flpms_pkg::*;
#(
    parameter int POOL_SLOTS = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    flpms_cmd_if.sink             i_cmd,
    flpms_res_if.source           o_res
);

    // Slots actually addressable: indices are 8 bits wide.
    localparam int NSLOT = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;
    localparam int AW    = $clog2(NSLOT);
    localparam int CW    = $clog2(NSLOT + 1);
    localparam int PW    = $clog2(POOL_SLOTS + 1);
    localparam int SW    = $clog2(POOL_SLOTS + 1);

    localparam logic [PW-1:0] NIL       = PW'(POOL_SLOTS);
    localparam logic [CW-1:0] LAST_SLOT = CW'(NSLOT - 1);
    localparam logic [SW-1:0] MAX_STEPS = SW'(POOL_SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_WALK_RD,
        S_WALK_WT,
        S_SCAN_RD,
        S_SCAN_WR,
        S_INIT,
        S_DONE
    } t_state;

    // Memories
    logic [PW-1:0] next_mem [NSLOT];
    logic          live_mem [NSLOT];

    logic          nxt_we;
    logic [AW-1:0] nxt_waddr;
    logic [PW-1:0] nxt_wdata;
    logic [AW-1:0] nxt_raddr;
    logic [PW-1:0] nxt_rdata;

    logic          live_we;
    logic [AW-1:0] live_waddr;
    logic          live_wdata;
    logic [AW-1:0] live_raddr;
    logic          live_rdata;

    // Control and datapath registers
    t_state            r_state,  n_state;
    logic [PW-1:0]     r_head,   n_head;
    logic [PW-1:0]     r_ptr,    n_ptr;
    logic [CW-1:0]     r_cnt,    n_cnt;
    logic [SW-1:0]     r_steps,  n_steps;
    logic [CFG_W-1:0]  r_pool_size;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [STAT_W-1:0] r_pend_status;

    logic              fin;
    logic [SLOT_W-1:0] fin_slot;
    logic [STAT_W-1:0] fin_status;
    logic              out_free;
    logic [CFG_W-1:0]  n_eff;
    logic [CW:0]       cnt_inc;
    logic              idx_bad;

    // Effective pool size, capped at the addressable slot count.
    assign n_eff    = (r_pool_size > CFG_W'(NSLOT)) ? CFG_W'(NSLOT) : r_pool_size;
    assign out_free = !r_out_valid || o_res.ready;
    assign cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign idx_bad  = CFG_W'(i_cmd.slot_index) >= n_eff;

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.result_slot = r_out_slot;
    assign o_res.status      = r_out_status;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_steps    = r_steps;
        fin        = 1'b0;
        fin_slot   = '0;
        fin_status = STAT_DONE;
        nxt_we     = 1'b0;
        nxt_waddr  = '0;
        nxt_wdata  = '0;
        nxt_raddr  = '0;
        live_we    = 1'b0;
        live_waddr = '0;
        live_wdata = 1'b0;
        live_raddr = '0;

        unique case (r_state)
            S_CLEAR: begin
                // post-reset pass: all marks cleared
                live_we    = 1'b1;
                live_waddr = r_cnt[AW-1:0];
                if (r_cnt == LAST_SLOT) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = CW'(cnt_inc);
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.command)
                        CMD_INIT: begin
                            n_cnt   = '0;
                            n_state = S_INIT;
                        end
                        CMD_ALLOC: begin
                            if (r_head >= NIL) begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end else begin
                                nxt_raddr = r_head[AW-1:0];
                                n_state   = S_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            fin = 1'b1;
                            if (idx_bad) begin
                                fin_status = STAT_RANGE;
                            end else begin
                                nxt_we    = 1'b1;
                                nxt_waddr = i_cmd.slot_index[AW-1:0];
                                nxt_wdata = r_head;
                                n_head    = PW'(i_cmd.slot_index);
                            end
                        end
                        CMD_MARK: begin
                            fin = 1'b1;
                            if (idx_bad) begin
                                fin_status = STAT_RANGE;
                            end else begin
                                live_we    = 1'b1;
                                live_waddr = i_cmd.slot_index[AW-1:0];
                                live_wdata = 1'b1;
                            end
                        end
                        CMD_SWEEP: begin
                            n_ptr   = r_head;
                            n_steps = '0;
                            n_state = S_WALK_RD;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_head   = nxt_rdata;
                fin      = 1'b1;
                fin_slot = SLOT_W'(r_head);
            end
            S_WALK_RD: begin
                // mark phase: everything on the free list counts as live
                if (r_ptr >= NIL || r_steps == MAX_STEPS) begin
                    n_cnt = '0;
                    if (n_eff == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    live_we    = 1'b1;
                    live_waddr = r_ptr[AW-1:0];
                    live_wdata = 1'b1;
                    nxt_raddr  = r_ptr[AW-1:0];
                    n_steps    = r_steps + 1'b1;
                    n_state    = S_WALK_WT;
                end
            end
            S_WALK_WT: begin
                n_ptr   = nxt_rdata;
                n_state = S_WALK_RD;
            end
            S_SCAN_RD: begin
                live_raddr = r_cnt[AW-1:0];
                n_state    = S_SCAN_WR;
            end
            S_SCAN_WR: begin
                // marked: unmark; unmarked: reclaim onto the list head
                if (live_rdata) begin
                    live_we    = 1'b1;
                    live_waddr = r_cnt[AW-1:0];
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_cnt[AW-1:0];
                    nxt_wdata = r_head;
                    n_head    = PW'(r_cnt);
                end
                if (CFG_W'(cnt_inc) == n_eff) begin
                    fin = 1'b1;
                end else begin
                    n_cnt   = CW'(cnt_inc);
                    n_state = S_SCAN_RD;
                end
            end
            S_INIT: begin
                live_we    = 1'b1;
                live_waddr = r_cnt[AW-1:0];
                if (CFG_W'(r_cnt) < n_eff) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_cnt[AW-1:0];
                    nxt_wdata = (CFG_W'(cnt_inc) < n_eff) ? PW'(cnt_inc) : NIL;
                end
                if (r_cnt == LAST_SLOT) begin
                    n_head = (n_eff == '0) ? NIL : '0;
                    fin    = 1'b1;
                end else begin
                    n_cnt = CW'(cnt_inc);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= NIL;
            r_ptr       <= NIL;
            r_cnt       <= '0;
            r_steps     <= '0;
            r_pool_size <= POOL_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_steps <= n_steps;
            if (i_cfg_we) begin
                r_pool_size <= i_cfg_wdata;
            end
            if (fin && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_slot   <= fin_slot;
                r_out_status <= fin_status;
            end else if (fin) begin
                r_pend_slot   <= fin_slot;
                r_pend_status <= fin_status;
            end else if (r_state == S_DONE && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_slot   <= r_pend_slot;
                r_out_status <= r_pend_status;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next-slot RAM
    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            next_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rdata <= next_mem[nxt_raddr];
    end

    // Live-mark RAM
    always_ff @(posedge i_clk) begin
        if (live_we) begin
            live_mem[live_waddr] <= live_wdata;
        end
        live_rdata <= live_mem[live_raddr];
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the slot pool: directed and random command streams checked against a predictor.

module tb
    import flpms_pkg::*;
();

    // Slot count of the block instance; the predictor mirrors it.
    localparam int POOL_SLOTS = 256;
    // List terminator used by the next-slot chain (empty list).
    localparam logic [8:0] LIST_END = 9'(POOL_SLOTS);
    // Command codes past sweep are unused; the block answers them with done.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_SWEEP + 1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;
    // Worst case is ~1100 transactions, each of them possibly a full-size sweep,
    // plus long gaps and stalls on both sides; take several times that.
    localparam int CYCLE_LIMIT = 10_000_000;
    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 80;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
    } t_pool_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    flpms_cmd_if cmd_if ();
    flpms_res_if res_if ();

    free_list_pool_with_mark_sweep #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    // ---------------------------------------------------------------------
    // Predictor state: its own copy of the pool and of the size register.
    // ---------------------------------------------------------------------
    logic [8:0]       link_mem [POOL_SLOTS];  // successor of each slot
    logic [8:0]       free_head;
    bit               live_bits [POOL_SLOTS];
    logic [CFG_W-1:0] pool_size_reg;

    t_pool_result expected_results [$];
    int           mismatches;
    int           cycle_count;
    bit           quiet;        // no gaps and no new stalls while set
    int           stall_left;

    // Slots in use: the register, capped at the slot count.
    function automatic int live_size();
        return (pool_size_reg > POOL_SLOTS) ? POOL_SLOTS : int'(pool_size_reg);
    endfunction

    // Applies one command to the predicted pool and returns its answer.
    function automatic t_pool_result pool_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [SLOT_W-1:0] idx);
        t_pool_result r;
        int           n;
        int           i;
        logic [8:0]   p;
        r = '0;
        r.status = STAT_DONE;
        n = live_size();
        case (cmd)
            CMD_INIT: begin
                for (i = 0; i < POOL_SLOTS; i++) live_bits[i] = 1'b0;
                if (n == 0) begin
                    free_head = LIST_END;
                end else begin
                    for (i = 0; i + 1 < n; i++) link_mem[i] = 9'(i + 1);
                    link_mem[n - 1] = LIST_END;
                    free_head = '0;
                end
            end
            CMD_ALLOC: begin
                if (free_head >= LIST_END) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.slot = free_head[SLOT_W-1:0];
                    free_head = link_mem[free_head];
                end
            end
            CMD_FREE: begin
                if (idx >= n) begin
                    r.status = STAT_RANGE;
                end else begin
                    link_mem[idx] = free_head;
                    free_head = {1'b0, idx};
                end
            end
            CMD_MARK: begin
                if (idx >= n) r.status = STAT_RANGE;
                else live_bits[idx] = 1'b1;
            end
            CMD_SWEEP: begin
                // Free-list walk is bounded so a looped list (double free) ends.
                p = free_head;
                for (i = 0; i < POOL_SLOTS && p < LIST_END; i++) begin
                    live_bits[p] = 1'b1;
                    p = link_mem[p];
                end
                for (i = 0; i < n; i++) begin
                    if (live_bits[i]) begin
                        live_bits[i] = 1'b0;
                    end else begin
                        link_mem[i] = free_head;
                        free_head = 9'(i);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // A random slot below the pool size that is not on the free list, or -1.
    function automatic int pick_owned();
        bit         on_list [POOL_SLOTS];
        int         owned [$];
        int         i;
        logic [8:0] p;
        p = free_head;
        for (i = 0; i < POOL_SLOTS && p < LIST_END; i++) begin
            on_list[p] = 1'b1;
            p = link_mem[p];
        end
        for (i = 0; i < live_size(); i++)
            if (!on_list[i]) owned.push_back(i);
        if (owned.size() == 0) return -1;
        return owned[$urandom_range(owned.size() - 1)];
    endfunction

    // Idle length: mostly short, a few long.
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // ---------------------------------------------------------------------
    // Clock, cycle limit
    // ---------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side backpressure, updated on the falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(4) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= pick_len() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Prediction and checking. Everything is sampled at the rising edge:
    // an accepted command is run through the predictor, an accepted result is
    // compared with the oldest expectation, a register write updates the size.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_pool_result want;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                expected_results.push_back(pool_apply(cmd_if.command, cmd_if.slot_index));
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transaction: slot %0d status %0d",
                                 res_if.result_slot, res_if.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.result_slot !== want.slot || res_if.status !== want.status) begin
                        if (mismatches < 10)
                            $display({"mismatch: expected slot %0d status %0d, ",
                                      "got slot %0d status %0d"},
                                     want.slot, want.status, res_if.result_slot,
                                     res_if.status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) pool_size_reg = i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // Driving (falling edge)
    // ---------------------------------------------------------------------

    // Sends one command transaction, with a random gap ahead of it, and
    // returns at the falling edge after it was taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx);
        int gap;
        gap = (quiet || $urandom_range(2) != 0) ? 0 : pick_len();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= cmd;
        cmd_if.slot_index <= idx;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    // Stops sending and waits for every outstanding result.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Size register write, only with the block idle.
    task automatic set_pool_size(input int size);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(size);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Pool out of reset: list empty, reset size. Sweep reclaims every slot.
    task automatic test_after_reset();
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_SWEEP, 8'hFF);
        send_item(CMD_ALLOC, 8'h00);
    endtask

    // Every command at full size, extreme indices, unused codes.
    task automatic test_basic_commands();
        set_pool_size(256);
        send_item(CMD_INIT, 8'hA5);
        send_item(CMD_ALLOC, 8'h5A);
        send_item(CMD_ALLOC, 8'hFF);
        send_item(CMD_MARK, 8'd1);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_MARK, 8'd255);
        send_item(CMD_UNUSED_LO, 8'hFF);
        send_item(CMD_UNUSED_HI, 8'h00);
        send_item(CMD_SWEEP, 8'h00);
        send_item(CMD_ALLOC, 8'h00);
    endtask

    // Size zero: empty list, every index out of range, pool exhausted.
    task automatic test_zero_pool();
        set_pool_size(0);
        send_item(CMD_INIT, 8'h00);
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_MARK, 8'd255);
        send_item(CMD_SWEEP, 8'h00);
    endtask

    // Shrinking the pool keeps old links usable; a double free loops the list.
    task automatic test_shrunk_pool();
        set_pool_size(8);
        send_item(CMD_INIT, 8'h00);
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_ALLOC, 8'h00);
        set_pool_size(2);
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_FREE, 8'd5);
        send_item(CMD_SWEEP, 8'h00);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_SWEEP, 8'h00);
        send_item(CMD_ALLOC, 8'h00);
    endtask

    // Random phases over several sizes. Most commands are well formed
    // (free/mark of slots actually handed out), the rest is noise.
    task automatic test_random_phases();
        int sizes [14] = '{3, 1, 12, 40, 256, 2, 0, 511, 25, 100, 9, 300, 6, 64};
        int ph;
        int k;
        int r;
        int owned;
        int idx_cap;
        logic [SLOT_W-1:0] junk;
        for (ph = 0; ph < $size(sizes); ph++) begin
            set_pool_size(sizes[ph]);
            quiet = ($urandom_range(3) == 0);
            // Now and then skip init so old links outlive a size change.
            if (ph == 0 || $urandom_range(4) != 0) send_item(CMD_INIT, 8'($urandom()));
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                r       = $urandom_range(99);
                junk    = 8'($urandom());
                owned   = pick_owned();
                idx_cap = (live_size() + 2 > 255) ? 255 : live_size() + 2;
                if (r < 38)
                    send_item(CMD_ALLOC, junk);
                else if (r < 58 && owned >= 0)
                    send_item(CMD_FREE, 8'(owned));
                else if (r < 72 && owned >= 0)
                    send_item(CMD_MARK, 8'(owned));
                else if (r < 84)
                    send_item($urandom_range(1) ? CMD_FREE : CMD_MARK,
                              $urandom_range(1) ? junk : 8'($urandom_range(idx_cap)));
                else if (r < 89)
                    send_item(CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), junk);
                else if (r < 97)
                    send_item(CMD_SWEEP, junk);
                else
                    send_item(CMD_INIT, junk);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_INIT;
        cmd_if.slot_index = '0;
        res_if.ready      = 1'b0;
        quiet             = 1'b0;
        stall_left        = 0;
        mismatches        = 0;
        cycle_count       = 0;
        // Predictor reset: empty list, no marks, reset size.
        free_head         = LIST_END;
        pool_size_reg     = POOL_SIZE_RST;
        foreach (live_bits[i]) live_bits[i] = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_basic_commands();
        test_zero_pool();
        test_shrunk_pool();
        test_random_phases();
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/flpms_pkg.sv
rtl/flpms_if.sv
rtl/free_list_pool_with_mark_sweep.sv
tb/sv/tb.sv
